### hw/rtl/scta_pkg.sv
// Shared types, constants and key tables for the scancode line buffer.
`timescale 1ns / 1ps
`default_nettype none

package scta_pkg;

    // Line buffer geometry
    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
    localparam int LEVEL_W      = 9;
    localparam int MAP_SIZE     = 58;

    // Set-1 scancodes of interest
    localparam logic [7:0] SC_PREFIX    = 8'hE0;
    localparam logic [6:0] SC_BACKSPACE = 7'h0E;
    localparam logic [6:0] SC_LCTRL     = 7'h1D;
    localparam logic [6:0] SC_LSHIFT    = 7'h2A;
    localparam logic [6:0] SC_RSHIFT    = 7'h36;
    localparam logic [6:0] SC_CAPS      = 7'h3A;
    localparam logic [6:0] SC_UP        = 7'h48;
    localparam logic [6:0] SC_LEFT      = 7'h4B;
    localparam logic [6:0] SC_RIGHT     = 7'h4D;
    localparam logic [6:0] SC_DOWN      = 7'h50;

    // Characters with special meaning
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_LOWER_L = 8'h6C;
    localparam logic [7:0] CH_UPPER_L = 8'h4C;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ARROW_UP    = 2'd0,
        REG_ARROW_DOWN  = 2'd1,
        REG_ARROW_LEFT  = 2'd2,
        REG_ARROW_RIGHT = 2'd3
    } t_reg_idx;

    // Echo actions
    typedef enum logic [1:0] {
        ECHO_NONE  = 2'd0,
        ECHO_CHAR  = 2'd1,
        ECHO_ERASE = 2'd2,
        ECHO_CLEAR = 2'd3
    } t_echo_action;

    // Request kinds
    typedef enum logic {
        REQ_SCAN = 1'b0,
        REQ_POP  = 1'b1
    } t_req_type;

    typedef struct packed {
        t_req_type  req_type;
        logic [7:0] scan_byte;
    } t_req;

    typedef struct packed {
        t_echo_action       echo_action;
        logic [7:0]         echo_char;
        logic               pop_valid;
        logic [7:0]         pop_char;
        logic [LEVEL_W-1:0] fill_level;
        logic               shift_out;
        logic               ctrl_out;
    } t_result;

    localparam logic [7:0] MAP_LOWER [MAP_SIZE] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    localparam logic [7:0] MAP_UPPER [MAP_SIZE] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    // Key to character; zero for keys with no character
    function automatic logic [7:0] key_to_char(input logic [6:0] key, input logic upper);
        logic [7:0] c;
        c = 8'h00;
        if (key < 7'(MAP_SIZE)) begin
            c = upper ? MAP_UPPER[key[5:0]] : MAP_LOWER[key[5:0]];
        end
        return c;
    endfunction

    // Ring pointer step forward
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(BUFFER_DEPTH - 1)) ? '0 : p + ADDR_W'(1);
    endfunction

    // Ring pointer step back
    function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
        return (p == '0) ? ADDR_W'(BUFFER_DEPTH - 1) : p - ADDR_W'(1);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/scta_req_if.sv
// Request channel: scancode byte or pop request, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface scta_req_if;
    logic          valid;
    logic          ready;
    scta_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/scta_res_if.sv
// Result channel: echo, pop and status fields, valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface scta_res_if;
    logic             valid;
    logic             ready;
    scta_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/scancode_to_ascii_line_buffer.sv
// Set-1 scancode decoder with ring line buffer, echo and pop results.
//
//  channel  | dir | handshake       | payload
//  ---------+-----+-----------------+-----------------------------------------
//  i_req    | in  | valid/ready     | req_type, scan_byte
//  o_res    | out | valid/ready     | echo_action, echo_char, pop_valid,
//           |     |                 | pop_char, fill_level, shift_out, ctrl_out
//  i_cfg_*  | in  | write enable    | register index, 8-bit data
//
// One request accepted per cycle while the result side does not stall; a
// request passes through the input register, then decode/update into the
// result register. Head and tail bytes are prefetched from the store each cycle
// with write bypass, so pop and backspace never stall. Reset is synchronous and
// leaves the store uncleared. A stalled result holds the result register; the
// input register takes one more request behind it, then ready drops.
`timescale 1ns / 1ps
`default_nettype none

module scancode_to_ascii_line_buffer (
    input  wire                i_clk,
    input  wire                i_rst_n,
    scta_req_if.sink           i_req,
    scta_res_if.source         o_res,
    input  wire                i_cfg_we,
    input  wire  [1:0]         i_cfg_idx,
    input  wire  [7:0]         i_cfg_data
);

    localparam int DEPTH = scta_pkg::BUFFER_DEPTH;
    localparam int AW    = scta_pkg::ADDR_W;
    localparam int FW    = scta_pkg::FILL_W;
    localparam int LW    = scta_pkg::LEVEL_W;

    // Configuration registers
    logic [7:0] r_arrow_up, r_arrow_down, r_arrow_left, r_arrow_right;

    // Input register
    logic              r_in_valid;
    scta_pkg::t_req    r_in;

    // Result register
    logic              r_out_valid;
    scta_pkg::t_result r_out;

    // Buffer and key state
    logic [7:0]    r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [FW-1:0] r_fill;
    logic          r_shift, r_ctrl, r_caps, r_prefix;

    // Prefetched store bytes at the read pointer and before the write pointer
    logic [7:0]    r_head, r_tail;

    logic          proc;
    logic [AW-1:0] n_wp, n_rp;
    logic [FW-1:0] n_fill;
    logic          n_shift, n_ctrl, n_caps, n_prefix;
    logic [AW-1:0] tail_addr;

    logic                   push_req, push_ok, push_echo;
    logic [7:0]             push_byte;
    logic                   release_bit;
    logic [6:0]             key;
    logic [7:0]             key_char;
    scta_pkg::t_echo_action act;
    logic [7:0]             echo_c;
    logic                   pop_v;
    logic [7:0]             pop_c;

    // Handshake: decode when the result register is free or being drained
    assign proc        = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_req.ready = !r_in_valid || proc;
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrow_up    <= 8'd128;
            r_arrow_down  <= 8'd129;
            r_arrow_left  <= 8'd130;
            r_arrow_right <= 8'd131;
        end else if (i_cfg_we) begin
            unique case (scta_pkg::t_reg_idx'(i_cfg_idx))
                scta_pkg::REG_ARROW_UP:    r_arrow_up    <= i_cfg_data;
                scta_pkg::REG_ARROW_DOWN:  r_arrow_down  <= i_cfg_data;
                scta_pkg::REG_ARROW_LEFT:  r_arrow_left  <= i_cfg_data;
                scta_pkg::REG_ARROW_RIGHT: r_arrow_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in <= i_req.data;
        end
    end

    assign release_bit = r_in.scan_byte[7];
    assign key         = r_in.scan_byte[6:0];
    assign key_char    = scta_pkg::key_to_char(key, r_shift ^ r_caps);

    // Decode one request against the current state
    always_comb begin
        n_wp      = r_wp;
        n_rp      = r_rp;
        n_fill    = r_fill;
        n_shift   = r_shift;
        n_ctrl    = r_ctrl;
        n_caps    = r_caps;
        n_prefix  = r_prefix;
        push_req  = 1'b0;
        push_echo = 1'b0;
        push_byte = 8'h00;
        act       = scta_pkg::ECHO_NONE;
        echo_c    = 8'h00;
        pop_v     = 1'b0;
        pop_c     = 8'h00;

        if (r_in.req_type == scta_pkg::REQ_POP) begin
            if (r_fill != '0) begin
                pop_v  = 1'b1;
                pop_c  = r_head;
                n_rp   = scta_pkg::ptr_inc(r_rp);
                n_fill = r_fill - FW'(1);
            end
        end else begin
            priority if (r_in.scan_byte == scta_pkg::SC_PREFIX) begin
                n_prefix = 1'b1;
            end else if (r_prefix) begin
                // extended key: only arrow presses do anything
                n_prefix = 1'b0;
                if (!release_bit) begin
                    priority if (key == scta_pkg::SC_UP) begin
                        push_req  = 1'b1;
                        push_byte = r_arrow_up;
                    end else if (key == scta_pkg::SC_DOWN) begin
                        push_req  = 1'b1;
                        push_byte = r_arrow_down;
                    end else if (key == scta_pkg::SC_LEFT) begin
                        push_req  = 1'b1;
                        push_byte = r_arrow_left;
                    end else if (key == scta_pkg::SC_RIGHT) begin
                        push_req  = 1'b1;
                        push_byte = r_arrow_right;
                    end else begin
                    end
                end
            end else if (key == scta_pkg::SC_LSHIFT || key == scta_pkg::SC_RSHIFT) begin
                n_shift = !release_bit;
            end else if (key == scta_pkg::SC_LCTRL) begin
                n_ctrl = !release_bit;
            end else if (release_bit) begin
            end else if (key == scta_pkg::SC_CAPS) begin
                n_caps = !r_caps;
            end else if (key == scta_pkg::SC_BACKSPACE) begin
                // erase unless empty or the last byte ends a line
                if (r_fill != '0 && r_tail != scta_pkg::CH_NEWLINE) begin
                    n_wp   = scta_pkg::ptr_dec(r_wp);
                    n_fill = r_fill - FW'(1);
                    act    = scta_pkg::ECHO_ERASE;
                end
            end else if (key_char != 8'h00) begin
                if (r_ctrl && (key_char == scta_pkg::CH_LOWER_L ||
                               key_char == scta_pkg::CH_UPPER_L)) begin
                    act = scta_pkg::ECHO_CLEAR;
                end else begin
                    push_req  = 1'b1;
                    push_echo = 1'b1;
                    push_byte = key_char;
                end
            end else begin
            end
        end

        // Push into the ring; a full buffer drops the byte silently
        push_ok = push_req && (r_fill < FW'(DEPTH));
        if (push_ok) begin
            n_wp   = scta_pkg::ptr_inc(r_wp);
            n_fill = r_fill + FW'(1);
            if (push_echo) begin
                act    = scta_pkg::ECHO_CHAR;
                echo_c = push_byte;
            end
        end

        // Hold everything when no request is decoded
        if (!proc) begin
            n_wp     = r_wp;
            n_rp     = r_rp;
            n_fill   = r_fill;
            n_shift  = r_shift;
            n_ctrl   = r_ctrl;
            n_caps   = r_caps;
            n_prefix = r_prefix;
            push_ok  = 1'b0;
        end
    end

    assign tail_addr = scta_pkg::ptr_dec(n_wp);

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_rp     <= '0;
            r_fill   <= '0;
            r_shift  <= 1'b0;
            r_ctrl   <= 1'b0;
            r_caps   <= 1'b0;
            r_prefix <= 1'b0;
        end else begin
            r_wp     <= n_wp;
            r_rp     <= n_rp;
            r_fill   <= n_fill;
            r_shift  <= n_shift;
            r_ctrl   <= n_ctrl;
            r_caps   <= n_caps;
            r_prefix <= n_prefix;
        end
    end

    // Line store: one write port, two registered read ports with bypass
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= push_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= (push_ok && n_rp == r_wp) ? push_byte : r_mem[n_rp];
        r_tail <= (push_ok && tail_addr == r_wp) ? push_byte : r_mem[tail_addr];
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out.echo_action <= act;
            r_out.echo_char   <= echo_c;
            r_out.pop_valid   <= pop_v;
            r_out.pop_char    <= pop_c;
            r_out.fill_level  <= LW'(n_fill);
            r_out.shift_out   <= n_shift;
            r_out.ctrl_out    <= n_ctrl;
        end
    end

    // Pointer consistency: read pointer plus fill wraps onto write pointer
    logic [FW:0] rp_plus_fill;
    logic [FW:0] rp_plus_fill_wrap;
    assign rp_plus_fill      = (FW + 1)'(r_rp) + (FW + 1)'(r_fill);
    assign rp_plus_fill_wrap = (rp_plus_fill >= (FW + 1)'(DEPTH)) ?
                               rp_plus_fill - (FW + 1)'(DEPTH) : rp_plus_fill;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count beyond buffer depth");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rp_plus_fill_wrap == (FW + 1)'(r_wp))
        else $error("ring pointers disagree with fill count");

    a_pop_no_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.pop_valid) |-> (r_out.echo_action == scta_pkg::ECHO_NONE))
        else $error("pop result carries an echo action");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in.req_type == scta_pkg::REQ_POP && r_fill != '0)
        |=> (r_fill == $past(r_fill) - FW'(1)))
        else $error("pop did not reduce fill count");

    a_echo_char_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.echo_action != scta_pkg::ECHO_CHAR)
        |-> (r_out.echo_char == 8'h00))
        else $error("echo character set without echo action");

endmodule

`default_nettype wire

### verif/scancode_to_ascii_line_buffer_tb.sv
// Self-checking bench for the scancode line buffer: echo, pop and status per request.
`timescale 1ns / 1ps

module scancode_to_ascii_line_buffer_tb;

    localparam int DEPTH = scta_pkg::BUFFER_DEPTH;
    localparam int AW    = scta_pkg::ADDR_W;

    // Key numbers used by the stimulus
    localparam logic [7:0] KEY_L     = 8'h26;
    localparam logic [7:0] KEY_SPACE = 8'h39;
    localparam logic [7:0] KEY_LAST  = 8'h39;

    // Character tables, unshifted and shifted
    localparam logic [7:0] LC_MAP [scta_pkg::MAP_SIZE] = '{
        8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
    };
    localparam logic [7:0] UC_MAP [scta_pkg::MAP_SIZE] = '{
        8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
    };

    // Keyboard state, line buffer and the queue of results still due
    class line_echo_board;
        logic [7:0]        store [DEPTH];
        int unsigned       wr_ptr, rd_ptr, held;
        logic              shift_on, ctrl_on, caps_on, prefix_on;
        logic [7:0]        arrow_code [4];
        scta_pkg::t_result results_due [$];
        int                fails;

        function new();
            arrow_code = '{8'd128, 8'd129, 8'd130, 8'd131};
            wr_ptr    = 0;
            rd_ptr    = 0;
            held      = 0;
            shift_on  = 1'b0;
            ctrl_on   = 1'b0;
            caps_on   = 1'b0;
            prefix_on = 1'b0;
            fails     = 0;
        endfunction

        function void set_reg(scta_pkg::t_reg_idx idx, logic [7:0] v);
            arrow_code[idx] = v;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // Append to the line; refused when full
        function bit store_byte(logic [7:0] c);
            if (held >= DEPTH) return 1'b0;
            store[AW'(wr_ptr)] = c;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            held++;
            return 1'b1;
        endfunction

        // Remove the newest byte unless it ends a line
        function bit drop_last();
            int unsigned last;
            if (held == 0) return 1'b0;
            last = (wr_ptr + DEPTH - 1) % DEPTH;
            if (store[AW'(last)] == scta_pkg::CH_NEWLINE) return 1'b0;
            wr_ptr = last;
            held--;
            return 1'b1;
        endfunction

        // Key state update and echo for one scancode
        function scta_pkg::t_result decode_scan(logic [7:0] sc);
            scta_pkg::t_result e;
            logic [6:0]        key;
            logic              rel;
            logic [7:0]        c;
            e = '0;
            if (sc == scta_pkg::SC_PREFIX) begin
                prefix_on = 1'b1;
                return e;
            end
            rel = sc[7];
            key = sc[6:0];
            // extended key: only arrow presses do anything, never echoed
            if (prefix_on) begin
                prefix_on = 1'b0;
                if (!rel) begin
                    case (key)
                        scta_pkg::SC_UP:
                            void'(store_byte(arrow_code[scta_pkg::REG_ARROW_UP]));
                        scta_pkg::SC_DOWN:
                            void'(store_byte(arrow_code[scta_pkg::REG_ARROW_DOWN]));
                        scta_pkg::SC_LEFT:
                            void'(store_byte(arrow_code[scta_pkg::REG_ARROW_LEFT]));
                        scta_pkg::SC_RIGHT:
                            void'(store_byte(arrow_code[scta_pkg::REG_ARROW_RIGHT]));
                        default: ;
                    endcase
                end
                return e;
            end
            if (key == scta_pkg::SC_LSHIFT || key == scta_pkg::SC_RSHIFT) begin
                shift_on = !rel;
                return e;
            end
            if (key == scta_pkg::SC_LCTRL) begin
                ctrl_on = !rel;
                return e;
            end
            if (rel) return e;
            if (key == scta_pkg::SC_CAPS) begin
                caps_on = !caps_on;
                return e;
            end
            if (key == scta_pkg::SC_BACKSPACE) begin
                if (drop_last()) e.echo_action = scta_pkg::ECHO_ERASE;
                return e;
            end
            if (key >= 7'(scta_pkg::MAP_SIZE)) return e;
            c = (shift_on ^ caps_on) ? UC_MAP[key[5:0]] : LC_MAP[key[5:0]];
            if (c == 8'h00) return e;
            if (ctrl_on && (c == scta_pkg::CH_LOWER_L || c == scta_pkg::CH_UPPER_L)) begin
                e.echo_action = scta_pkg::ECHO_CLEAR;
                return e;
            end
            if (store_byte(c)) begin
                e.echo_action = scta_pkg::ECHO_CHAR;
                e.echo_char   = c;
            end
            return e;
        endfunction

        function void note_request(scta_pkg::t_req r);
            scta_pkg::t_result e;
            if (r.req_type == scta_pkg::REQ_POP) begin
                e = '0;
                if (held > 0) begin
                    e.pop_valid = 1'b1;
                    e.pop_char  = store[AW'(rd_ptr)];
                    rd_ptr = (rd_ptr + 1) % DEPTH;
                    held--;
                end
            end else begin
                e = decode_scan(r.scan_byte);
            end
            e.fill_level = scta_pkg::LEVEL_W'(held);
            e.shift_out  = shift_on;
            e.ctrl_out   = ctrl_on;
            results_due.push_back(e);
        endfunction

        function void cmp_field(string field, logic [8:0] want, logic [8:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, actual %0h", field, want, got);
                fails++;
            end
        endfunction

        function void check_result(scta_pkg::t_result got);
            scta_pkg::t_result want;
            if (results_due.size() == 0) begin
                $error("result with no request outstanding: %p", got);
                fails++;
                return;
            end
            want = results_due.pop_front();
            cmp_field("echo_action", 9'(want.echo_action), 9'(got.echo_action));
            cmp_field("echo_char", 9'(want.echo_char), 9'(got.echo_char));
            cmp_field("pop_valid", 9'(want.pop_valid), 9'(got.pop_valid));
            cmp_field("pop_char", 9'(want.pop_char), 9'(got.pop_char));
            cmp_field("fill_level", 9'(want.fill_level), 9'(got.fill_level));
            cmp_field("shift_out", 9'(want.shift_out), 9'(got.shift_out));
            cmp_field("ctrl_out", 9'(want.ctrl_out), 9'(got.ctrl_out));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    scta_pkg::t_reg_idx cfg_idx;
    logic [7:0]         cfg_data;
    logic               quiet;
    int                 sent_count = 0;

    line_echo_board sb = new();

    scta_req_if req_ch ();
    scta_res_if res_ch ();

    scancode_to_ascii_line_buffer u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop
    initial begin
        #500_000;
        $display("FAILURE");
        $finish;
    end

    // Result side stalls, none during the quiet stretch
    always @(posedge clk) begin
        res_ch.ready <= quiet || ($urandom_range(99) >= 20);
    end

    // Both handshakes sampled on the same edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
            if (res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
        end
    end

    // One request, with an occasional gap ahead of it; valid stays up afterwards
    task automatic send(input scta_pkg::t_req r);
        if (!quiet && $urandom_range(99) < 20) begin
            req_ch.valid <= 1'b0;
            repeat (($urandom_range(7) == 0) ? $urandom_range(2, 6) : 1) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_scan(input logic [7:0] b);
        scta_pkg::t_req r;
        r.req_type  = scta_pkg::REQ_SCAN;
        r.scan_byte = b;
        send(r);
    endtask

    task automatic send_pop(input logic [7:0] junk);
        scta_pkg::t_req r;
        r.req_type  = scta_pkg::REQ_POP;
        r.scan_byte = junk;
        send(r);
    endtask

    // Let every outstanding request come back, then a little slack
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input scta_pkg::t_reg_idx idx, input logic [7:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
    endtask

    task automatic set_arrow_codes(input logic [7:0] up, dn, lf, rt);
        put_reg(scta_pkg::REG_ARROW_UP, up);
        put_reg(scta_pkg::REG_ARROW_DOWN, dn);
        put_reg(scta_pkg::REG_ARROW_LEFT, lf);
        put_reg(scta_pkg::REG_ARROW_RIGHT, rt);
        cfg_we <= 1'b0;
    endtask

    // One short, mostly well-formed key sequence with random content
    task automatic random_burst();
        int         kind;
        int         sub;
        logic [7:0] k;
        logic [6:0] arrows [4];
        arrows = '{scta_pkg::SC_UP, scta_pkg::SC_DOWN, scta_pkg::SC_LEFT, scta_pkg::SC_RIGHT};
        kind = $urandom_range(99);
        if (kind < 38) begin
            // plain typing, some keys released
            repeat ($urandom_range(1, 4)) begin
                k = 8'($urandom_range(1, KEY_LAST));
                send_scan(k);
                if ($urandom_range(9) < 3) send_scan(k | 8'h80);
            end
        end else if (kind < 48) begin
            send_scan({1'b0, ($urandom_range(1) != 0) ? scta_pkg::SC_LSHIFT
                                                       : scta_pkg::SC_RSHIFT});
            repeat ($urandom_range(1, 3)) send_scan(8'($urandom_range(1, KEY_LAST)));
            send_scan({1'b1, ($urandom_range(1) != 0) ? scta_pkg::SC_LSHIFT
                                                       : scta_pkg::SC_RSHIFT});
        end else if (kind < 55) begin
            send_scan({1'b0, scta_pkg::SC_LCTRL});
            send_scan(($urandom_range(1) != 0) ? KEY_L : 8'($urandom_range(1, KEY_LAST)));
            send_scan({1'b1, scta_pkg::SC_LCTRL});
        end else if (kind < 59) begin
            send_scan({1'b0, scta_pkg::SC_CAPS});
        end else if (kind < 69) begin
            // extended sequences: mostly arrow presses
            send_scan(scta_pkg::SC_PREFIX);
            sub = $urandom_range(9);
            if (sub == 0) begin
                send_scan(scta_pkg::SC_PREFIX);
                send_scan({1'b0, arrows[2'($urandom_range(3))]});
            end else if (sub == 1) begin
                send_scan({1'b1, arrows[2'($urandom_range(3))]});
            end else if (sub == 2) begin
                send_scan(8'($urandom_range(255)));
            end else begin
                send_scan({1'b0, arrows[2'($urandom_range(3))]});
            end
        end else if (kind < 75) begin
            send_scan({1'b0, scta_pkg::SC_BACKSPACE});
        end else if (kind < 93) begin
            repeat ($urandom_range(1, 6)) send_pop(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(1) != 0) send_pop(8'($urandom_range(255)));
            else send_scan(8'($urandom_range(255)));
        end
    endtask

    initial begin
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        cfg_we       <= 1'b0;
        cfg_idx      <= scta_pkg::REG_ARROW_UP;
        cfg_data     <= 8'h00;
        quiet        <= 1'b0;
        rst_n        <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset arrow codes
        send_pop(8'hFF);                              // empty buffer
        send_scan(8'h00);                             // key with no character
        send_scan(8'hFF);                             // release of an unmapped key
        send_scan(8'h1E);                             // 'a'
        send_scan({1'b0, scta_pkg::SC_RSHIFT});
        send_scan(8'h10);                             // 'Q'
        send_scan({1'b0, scta_pkg::SC_CAPS});         // caps on while shifted
        send_scan(8'h02);                             // shift and caps cancel: '1'
        send_scan({1'b1, scta_pkg::SC_LSHIFT});
        send_scan(8'h1E);                             // 'A' from caps alone
        send_scan({1'b1, scta_pkg::SC_CAPS});         // release ignored
        send_scan({1'b0, scta_pkg::SC_CAPS});         // caps off
        send_scan({1'b0, scta_pkg::SC_LCTRL});
        send_scan(KEY_L);                             // screen clear
        send_scan({1'b1, scta_pkg::SC_LCTRL});
        send_scan(scta_pkg::SC_PREFIX);
        send_scan(scta_pkg::SC_PREFIX);               // prefix stays pending
        send_scan({1'b0, scta_pkg::SC_UP});
        send_scan(scta_pkg::SC_PREFIX);
        send_scan({1'b1, scta_pkg::SC_UP});           // extended release ignored
        send_scan(8'h1C);                             // newline
        send_scan({1'b0, scta_pkg::SC_BACKSPACE});    // blocked by the newline
        send_scan(KEY_SPACE);
        send_scan({1'b0, scta_pkg::SC_BACKSPACE});    // erases the space
        send_pop(8'h00);
        settle();

        // Extreme arrow codes, random traffic
        set_arrow_codes(8'h00, 8'hFF, 8'h01, 8'hFE);
        while (sent_count < 375) random_burst();
        settle();

        // Fill the line to the brim, hit it while full, then drain past empty
        set_arrow_codes(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
        repeat (DEPTH + 6) send_scan(8'($urandom_range(8'h10, 8'h19)));
        send_scan(scta_pkg::SC_PREFIX);
        send_scan({1'b0, scta_pkg::SC_DOWN});         // arrow dropped when full
        send_scan({1'b0, scta_pkg::SC_BACKSPACE});
        send_scan(KEY_SPACE);
        send_scan(KEY_SPACE);                         // dropped, no echo
        repeat (DEPTH + 4) send_pop(8'($urandom_range(255)));
        settle();

        // Opposite extremes; a stretch with no gaps on either side
        set_arrow_codes(8'hFF, 8'h00, 8'h5A, 8'hA5);
        while (sent_count < 950) random_burst();
        quiet <= 1'b1;
        while (sent_count < 1080) random_burst();
        quiet <= 1'b0;
        while (sent_count < 1180) random_burst();
        settle();

        if (sb.fails == 0 && sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/scta_pkg.sv
hw/rtl/scta_req_if.sv
hw/rtl/scta_res_if.sv
hw/rtl/scancode_to_ascii_line_buffer.sv
verif/scancode_to_ascii_line_buffer_tb.sv
